### design/bhs_pkg.sv
// Shared constants and helpers for the byte histogram block.
package bhs_pkg;

  localparam int NumBins  = 256;
  localparam int BinAw    = $clog2(NumBins);
  localparam int CntW     = 20;
  localparam int DistW    = BinAw + 1;
  localparam int FracW    = 8;
  localparam int AvgW     = CntW + FracW;
  localparam int DivSteps = AvgW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Operation codes carried in the input tuser
  localparam logic OpCount = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Packed result layout, lowest field first
  localparam int OutDataW = CntW * 3 + DistW + AvgW;
  localparam int OutBusW  = ((OutDataW + 7) / 8) * 8;

  typedef struct packed {
    logic [CntW-1:0]  total;
    logic [CntW-1:0]  max;
    logic [DistW-1:0] used;
    logic             ovf;
  } stats_t;

endpackage

### design/bhs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bhs_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/bhs_div.sv
// Restoring divider, one quotient bit per cycle, for the per-bin average.
module bhs_div
  import bhs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AvgW-1:0]  dividend_i,
  input  logic [DistW-1:0] divisor_i,
  output logic             done_o,
  output logic [AvgW-1:0]  quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DistW-1:0]   rem_q, rem_d;
  logic [AvgW-1:0]    quo_q;
  logic [DistW-1:0]   dvs_q;
  logic [DistW:0]     rem_sh;
  logic [DistW:0]     rem_sub;
  logic               qbit;

  assign rem_sh  = {rem_q, quo_q[AvgW-1]};
  assign qbit    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  // remainder stays below the divisor, so it fits DistW bits
  assign rem_d   = qbit ? rem_sub[DistW-1:0] : rem_sh[DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[AvgW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### design/byte_histogram_with_stats_top.sv
// Byte histogram with per-block statistics: control, bin memory and output register.
//
// Input beats arrive on s_axis: tdata carries the byte, tuser selects count or
// query and flags the start of a block, tlast marks the block's last byte.
// Every input beat gives exactly one result beat on m_axis with the bin's count
// (updated by a count beat), the block maximum, the total, the used bin count, the mean
// count per used bin (Q20.8) and a saturation flag in tuser; tlast echoes the input.
// A count beat with the start flag clears all bins and statistics first.
// Items are handled one at a time: the bin is read from the bin RAM, then
// modified and written back, the bit-serial divider forms the mean, the
// quotient is handed over and the output register is loaded; only then is the
// next beat taken. A query while no bin is used skips the divider.
// The bins carry one valid flop each; reset and a block start clear them all
// at once, so there is no clearing pass and the block is ready at once.
// The result waits in the output register while m_axis_tready is low; the next
// input beat is still taken, and its result holds until the register drains.
module byte_histogram_with_stats_top
  import bhs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] sym_byte
  input  logic [1:0]          s_axis_tuser,  // [0] operation, [1] start_block
  input  logic                s_axis_tlast,  // last_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [19:0] bin_count, [39:20] max_count, [59:40] total_count,
  // [68:60] distinct_symbols, [96:69] average_count, rest zero
  output logic [OutBusW-1:0]  m_axis_tdata,
  output logic [0:0]          m_axis_tuser,  // [0] saturated
  output logic                m_axis_tlast   // block_end
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRmw  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [NumBins-1:0] valid_q;
  stats_t             stats_q, stats_d;
  logic               op_q, last_q;
  logic [BinAw-1:0]   idx_q;
  logic [CntW-1:0]    bin_q, bin_d;
  logic [AvgW-1:0]    avg_q;
  logic               out_valid_q;
  logic [OutBusW-1:0] out_data_q;
  logic               out_sat_q, out_last_q;

  logic               in_acc;
  logic               clr;
  logic [CntW-1:0]    ram_rdata;
  logic               ram_we;
  logic [CntW-1:0]    c_old, c_new;
  logic               is_cnt;
  logic               div_start, div_done;
  logic [AvgW-1:0]    div_quot;
  logic               out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign clr           = in_acc & (s_axis_tuser[0] == OpCount) & s_axis_tuser[1];

  bhs_ram #(
    .Width(CntW),
    .Depth(NumBins)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (c_new),
    .re_i    (in_acc),
    .raddr_i (s_axis_tdata),
    .rdata_o (ram_rdata)
  );

  // read-modify-write of the addressed bin for a count; a query only reads it
  always_comb begin
    is_cnt  = (op_q == OpCount);
    c_old   = valid_q[idx_q] ? ram_rdata : '0;
    c_new   = (c_old == CntMax) ? CntMax : c_old + 1'b1;
    stats_d = stats_q;
    bin_d   = c_old;
    if (is_cnt) begin
      bin_d = c_new;
      if (c_old == '0) begin
        stats_d.used = stats_q.used + 1'b1;
      end
      if (c_new > stats_q.max) begin
        stats_d.max = c_new;
      end
      if (stats_q.total != CntMax) begin
        stats_d.total = stats_q.total + 1'b1;
      end
      if (c_old >= CntMax - 1'b1 || stats_q.total >= CntMax - 1'b1) begin
        stats_d.ovf = 1'b1;
      end
    end
  end

  assign ram_we    = (state_q == StRmw) & is_cnt;
  assign div_start = (state_q == StRmw) & (stats_d.used != '0);
  assign out_load  = (state_q == StOut) & (~out_valid_q | m_axis_tready);

  bhs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({stats_d.total, {FracW{1'b0}}}),
    .divisor_i  (stats_d.used),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) state_d = StRmw;
      end
      StRmw: begin
        state_d = div_start ? StDiv : StOut;
      end
      StDiv: begin
        if (div_done) state_d = StOut;
      end
      StOut: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      stats_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        valid_q <= '0;
        stats_q <= '0;
      end else if (state_q == StRmw) begin
        stats_q <= stats_d;
        if (is_cnt) valid_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser[0];
      idx_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    if (state_q == StRmw) begin
      bin_q <= bin_d;
      avg_q <= '0;
    end else if (div_done) begin
      avg_q <= div_quot;
    end
    if (out_load) begin
      out_data_q <= OutBusW'({avg_q, stats_q.used, stats_q.total, stats_q.max, bin_q});
      out_sat_q  <= stats_q.ovf;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tlast  = out_last_q;

endmodule

### design/bhs_chk.sv
// Port-level checker for the byte histogram block, bound to the top level.
module bhs_chk
  import bhs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [OutBusW-1:0] m_axis_tdata
);

  logic [CntW-1:0]  bin_f, max_f, tot_f;
  logic [DistW-1:0] used_f;
  logic [AvgW-1:0]  avg_f;

  assign bin_f  = m_axis_tdata[CntW-1:0];
  assign max_f  = m_axis_tdata[2*CntW-1:CntW];
  assign tot_f  = m_axis_tdata[3*CntW-1:2*CntW];
  assign used_f = m_axis_tdata[3*CntW+DistW-1:3*CntW];
  assign avg_f  = m_axis_tdata[OutDataW-1:3*CntW+DistW];

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_bin_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> bin_f <= max_f && max_f <= tot_f)
    else $error("bin, maximum and total out of order");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> used_f <= DistW'(NumBins))
    else $error("distinct count above bin count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && used_f == '0 |-> avg_f == '0 && tot_f == '0)
    else $error("empty histogram with nonzero total or mean");

endmodule

bind byte_histogram_with_stats_top bhs_chk u_bhs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
